// ===== rtl/tilt_angle_display_coder_core_assert.svh =====
// Assertion macros shared by the checker of the tilt angle display coder.
// Needs no other file; the including scope must provide clk and arst_n.
`ifndef TILT_ANGLE_DISPLAY_CODER_CORE_ASSERT_SVH
`define TILT_ANGLE_DISPLAY_CODER_CORE_ASSERT_SVH

// Property that must hold in the same cycle, outside reset.
`define TADC_ASSERT_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent, outside reset.
`define TADC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tadc_pkg.sv =====
// Package of the tilt angle display coder: widths, register codes, constants
// and the small decode functions. Depends on nothing.
package tadc_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int CFG_BITS      = 12;
	localparam int CFG_IDX_BITS  = 3;
	localparam int ANGLE_BITS    = 7;
	localparam int OUT_DATA_BITS = 24;
	localparam int Q_BITS        = 16;
	localparam int DIV_STAGES    = 8;
	localparam int DIV_STEP      = Q_BITS / DIV_STAGES;

	localparam logic [ANGLE_BITS-1:0] FULL_DEG = 7'd90;

	// Register reset values.
	localparam logic [CFG_BITS-1:0] RST_MID       = 12'd2840;
	localparam logic [CFG_BITS-1:0] RST_HALF_SPAN = 12'd280;
	localparam logic [CFG_BITS-1:0] RST_ZB_LOW    = 12'd2835;
	localparam logic [CFG_BITS-1:0] RST_ZB_HIGH   = 12'd2850;
	localparam logic [CFG_BITS-1:0] RST_POS_LIMIT = 12'd3115;
	localparam logic [CFG_BITS-1:0] RST_NEG_LIMIT = 12'd2565;

	// Reciprocals for the series coefficients, valid for 16-bit operands.
	// floor(x/6) = (x*43691)>>18, floor(3x/40) = (x*629148)>>23,
	// floor(15x/336) = floor(5x/112) = (x*748985)>>24.
	localparam logic [15:0] RECIP_C3 = 16'd43691;
	localparam int          SHIFT_C3 = 18;
	localparam logic [19:0] RECIP_C5 = 20'd629148;
	localparam int          SHIFT_C5 = 23;
	localparam logic [19:0] RECIP_C7 = 20'd748985;
	localparam int          SHIFT_C7 = 24;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MID       = 3'd0,
		REG_HALF_SPAN = 3'd1,
		REG_ZB_LOW    = 3'd2,
		REG_ZB_HIGH   = 3'd3,
		REG_POS_LIMIT = 3'd4,
		REG_NEG_LIMIT = 3'd5
	} cfg_reg_t;

	// How the angle of an item is formed.
	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_FULL,
		CLS_SERIES
	} ang_cls_t;

	typedef struct packed {
		logic     neg;
		ang_cls_t cls;
	} tag_t;

	function automatic logic [3:0] tens_of(input logic [ANGLE_BITS-1:0] a);
		logic [3:0] r;
		r = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (a >= ANGLE_BITS'(10 * k)) begin
				r = 4'(k);
			end
		end
		return r;
	endfunction

	function automatic logic [3:0] ones_of(input logic [ANGLE_BITS-1:0] a);
		logic [ANGLE_BITS-1:0] r;
		r = a - ANGLE_BITS'(tens_of(a)) * 7'd10;
		return r[3:0];
	endfunction

	// Thermometer bar, LEDs lit from bit 7 downward.
	function automatic logic [7:0] bar_of(input logic [ANGLE_BITS-1:0] a);
		logic [3:0] n;
		if (a >= 7'd90) begin
			n = 4'd8;
		end else if (a >= 7'd79) begin
			n = 4'd7;
		end else if (a >= 7'd68) begin
			n = 4'd6;
		end else if (a >= 7'd57) begin
			n = 4'd5;
		end else if (a >= 7'd45) begin
			n = 4'd4;
		end else if (a >= 7'd34) begin
			n = 4'd3;
		end else if (a >= 7'd23) begin
			n = 4'd2;
		end else if (a >= 7'd11) begin
			n = 4'd1;
		end else begin
			n = 4'd0;
		end
		return ~(8'hFF >> n);
	endfunction

endpackage

// ===== rtl/tilt_angle_display_coder_core.sv =====
// Top level of the tilt angle display coder: pipelined divider, arcsin
// series and display encoding. Depends on tadc_pkg.
//
// Channel   Dir  Signals                          Content
// s_*       in   s_tvalid s_tready s_tdata[15:0]  sample in bits 11:0
// m_*       out  m_tvalid m_tready m_tdata[23:0]  angle, sign, digits, bar
// cfg_*     in   cfg_valid cfg_ready cfg_index    register write, 12-bit data
//
// One request is taken every cycle while the output is not stalled: the 16-bit quotient
// comes from eight divider stages of two bits each, and each multiplication has a stage.
// Reset clears the valid bits and loads the register reset values.
// The whole pipeline moves as one: it advances when the output register is
// empty or its result is being taken, so a stall holds every stage in place.
module tilt_angle_display_coder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tadc_pkg::IN_DATA_BITS-1:0]   s_tdata,   // [11:0] sample, rest zero
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tadc_pkg::OUT_DATA_BITS-1:0]  m_tdata,   // [6:0] angle_deg,
	                                                       // [7] is_negative,
	                                                       // [11:8] tens_digit,
	                                                       // [15:12] ones_digit,
	                                                       // [23:16] bar_mask
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tadc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [tadc_pkg::CFG_BITS-1:0]       cfg_data
);

	localparam int NSTG = tadc_pkg::DIV_STAGES + 9;
	localparam int QB   = tadc_pkg::Q_BITS;
	localparam int CB   = tadc_pkg::CFG_BITS;
	localparam int AB   = tadc_pkg::ANGLE_BITS;

	// Configuration registers. The user must make writes arrive only while the
	// pipeline is empty; the block does not enforce this. Every stage reads them directly.
	logic [CB-1:0] mid_q, half_span_q, zb_low_q, zb_high_q, pos_limit_q, neg_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q       <= tadc_pkg::RST_MID;
			half_span_q <= tadc_pkg::RST_HALF_SPAN;
			zb_low_q    <= tadc_pkg::RST_ZB_LOW;
			zb_high_q   <= tadc_pkg::RST_ZB_HIGH;
			pos_limit_q <= tadc_pkg::RST_POS_LIMIT;
			neg_limit_q <= tadc_pkg::RST_NEG_LIMIT;
		end else if (cfg_valid) begin
			unique case (tadc_pkg::cfg_reg_t'(cfg_index))
				tadc_pkg::REG_MID:       mid_q       <= cfg_data;
				tadc_pkg::REG_HALF_SPAN: half_span_q <= cfg_data;
				tadc_pkg::REG_ZB_LOW:    zb_low_q    <= cfg_data;
				tadc_pkg::REG_ZB_HIGH:   zb_high_q   <= cfg_data;
				tadc_pkg::REG_POS_LIMIT: pos_limit_q <= cfg_data;
				tadc_pkg::REG_NEG_LIMIT: neg_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline control: one valid bit per stage, all stages move together.
	logic [NSTG:1] valid_s;
	logic          advance;

	assign advance  = !valid_s[NSTG] || m_tready;
	assign s_tready = advance;
	assign m_tvalid = valid_s[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (advance) begin
			valid_s <= {valid_s[NSTG-1:1], s_tvalid};
		end
	end

	// Stage 1: classify the sample and form the distance from mid. Items in the zero band,
	// beyond a limit, with a ratio of at least one or with zero distance skip the series.
	logic [tadc_pkg::SAMPLE_BITS-1:0] x;
	logic          pos_side, zero_band, sat;
	logic [CB-1:0] d_up, d_dn, d;
	tadc_pkg::tag_t tag_c;

	always_comb begin
		x         = s_tdata[tadc_pkg::SAMPLE_BITS-1:0];
		pos_side  = x >= zb_high_q;
		zero_band = !pos_side && (x >= zb_low_q);
		d_up      = (x > mid_q) ? (x - mid_q) : '0;
		d_dn      = (x < mid_q) ? (mid_q - x) : '0;
		d         = pos_side ? d_up : d_dn;
		sat       = pos_side ? (x > pos_limit_q) : (x <= neg_limit_q);
		tag_c.neg = !pos_side && !zero_band;
		if (zero_band) begin
			tag_c.cls = tadc_pkg::CLS_ZERO;
		end else if (sat) begin
			tag_c.cls = tadc_pkg::CLS_FULL;
		end else if (d == '0) begin
			tag_c.cls = tadc_pkg::CLS_ZERO;
		end else if (d >= half_span_q) begin
			tag_c.cls = tadc_pkg::CLS_FULL;
		end else begin
			tag_c.cls = tadc_pkg::CLS_SERIES;
		end
	end

	tadc_pkg::tag_t tag_s1;
	logic [CB-1:0]  d_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			tag_s1 <= tag_c;
			d_s1   <= (tag_c.cls == tadc_pkg::CLS_SERIES) ? d : '0;
		end
	end

	// Stages 2 to 9: restoring division of d * 2^16 by half_span. The
	// dividend is below the divisor, so every remainder fits in 12 bits and
	// the quotient in 16; two quotient bits are settled per stage.
	logic [CB-1:0]  div_rem_s [tadc_pkg::DIV_STAGES];
	logic [QB-1:0]  div_quo_s [tadc_pkg::DIV_STAGES];
	tadc_pkg::tag_t div_tag_s [tadc_pkg::DIV_STAGES];
	logic [CB-1:0]  div_rem_nx [tadc_pkg::DIV_STAGES];
	logic [QB-1:0]  div_quo_nx [tadc_pkg::DIV_STAGES];

	always_comb begin
		logic [CB-1:0] r;
		logic [CB:0]   r2;
		logic [QB-1:0] q;
		for (int k = 0; k < tadc_pkg::DIV_STAGES; k++) begin
			r = (k == 0) ? d_s1 : div_rem_s[(k == 0) ? 0 : k - 1];
			q = (k == 0) ? '0 : div_quo_s[(k == 0) ? 0 : k - 1];
			for (int j = 0; j < tadc_pkg::DIV_STEP; j++) begin
				r2 = {r, 1'b0};
				if (r2 >= {1'b0, half_span_q}) begin
					r2 = r2 - {1'b0, half_span_q};
					q  = {q[QB-2:0], 1'b1};
				end else begin
					q  = {q[QB-2:0], 1'b0};
				end
				r = r2[CB-1:0];
			end
			div_rem_nx[k] = r;
			div_quo_nx[k] = q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < tadc_pkg::DIV_STAGES; k++) begin
				div_rem_s[k] <= div_rem_nx[k];
				div_quo_s[k] <= div_quo_nx[k];
				div_tag_s[k] <= (k == 0) ? tag_s1 : div_tag_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	// Stages 10 to 16: powers of t, coefficient terms, sum and scaling.
	logic [QB-1:0] t_c;
	logic [31:0]   p_t2, p_t3, p_t5, p_t7;
	logic [31:0]   p_a3;
	logic [35:0]   p_b5, p_c7;
	logic [23:0]   p_deg;

	logic [QB-1:0] t_s10, t2_s10;
	logic [QB-1:0] t_s11, t2_s11, t3_s11;
	logic [QB-1:0] t_s12, t2_s12, t5_s12;
	logic [13:0]   a3_s12, a3_s13, a3_s14;
	logic [QB-1:0] t_s13, t7_s13, t_s14;
	logic [12:0]   b5_s13, b5_s14;
	logic [11:0]   c7_s14;
	logic [QB:0]   sum_s15;
	logic [AB-1:0] angle_s16;
	tadc_pkg::tag_t tag_s10, tag_s11, tag_s12, tag_s13, tag_s14, tag_s15;
	logic          neg_s16;

	assign t_c   = div_quo_s[tadc_pkg::DIV_STAGES-1];
	assign p_t2  = t_c * t_c;
	assign p_t3  = t2_s10 * t_s10;
	assign p_t5  = t3_s11 * t2_s11;
	assign p_a3  = t3_s11 * tadc_pkg::RECIP_C3;
	assign p_t7  = t5_s12 * t2_s12;
	assign p_b5  = t5_s12 * tadc_pkg::RECIP_C5;
	assign p_c7  = t7_s13 * tadc_pkg::RECIP_C7;
	assign p_deg = sum_s15 * 7'd90;

	logic [7:0]    deg_hi;
	logic [AB-1:0] angle_c;

	always_comb begin
		deg_hi = p_deg[23:16];
		unique case (tag_s15.cls)
			tadc_pkg::CLS_ZERO:   angle_c = '0;
			tadc_pkg::CLS_FULL:   angle_c = tadc_pkg::FULL_DEG;
			tadc_pkg::CLS_SERIES: angle_c = (deg_hi > 8'(tadc_pkg::FULL_DEG)) ?
			                                tadc_pkg::FULL_DEG : deg_hi[AB-1:0];
			default:              angle_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			t_s10     <= t_c;
			t2_s10    <= p_t2[31:16];
			tag_s10   <= div_tag_s[tadc_pkg::DIV_STAGES-1];

			t_s11     <= t_s10;
			t2_s11    <= t2_s10;
			t3_s11    <= p_t3[31:16];
			tag_s11   <= tag_s10;

			t_s12     <= t_s11;
			t2_s12    <= t2_s11;
			t5_s12    <= p_t5[31:16];
			a3_s12    <= p_a3[tadc_pkg::SHIFT_C3 +: 14];
			tag_s12   <= tag_s11;

			t_s13     <= t_s12;
			a3_s13    <= a3_s12;
			t7_s13    <= p_t7[31:16];
			b5_s13    <= p_b5[tadc_pkg::SHIFT_C5 +: 13];
			tag_s13   <= tag_s12;

			t_s14     <= t_s13;
			a3_s14    <= a3_s13;
			b5_s14    <= b5_s13;
			c7_s14    <= p_c7[tadc_pkg::SHIFT_C7 +: 12];
			tag_s14   <= tag_s13;

			sum_s15   <= {1'b0, t_s14} + (QB+1)'(a3_s14) + (QB+1)'(b5_s14)
			             + (QB+1)'(c7_s14);
			tag_s15   <= tag_s14;

			angle_s16 <= angle_c;
			neg_s16   <= tag_s15.neg;
		end
	end

	// Stage 17: output register with the display encoding.
	logic [AB-1:0] angle_s17;
	logic          neg_s17;
	logic [3:0]    tens_s17, ones_s17;
	logic [7:0]    bar_s17;

	always_ff @(posedge clk) begin
		if (advance) begin
			angle_s17 <= angle_s16;
			neg_s17   <= neg_s16;
			tens_s17  <= tadc_pkg::tens_of(angle_s16);
			ones_s17  <= tadc_pkg::ones_of(angle_s16);
			bar_s17   <= tadc_pkg::bar_of(angle_s16);
		end
	end

	assign m_tdata = {bar_s17, ones_s17, tens_s17, neg_s17, angle_s17};

endmodule

// ===== rtl/tadc_checker.sv =====
// Port-level checker of the tilt angle display coder and its bind.
// Depends on tadc_pkg and tilt_angle_display_coder_core_assert.svh.
`include "tilt_angle_display_coder_core_assert.svh"

module tadc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [tadc_pkg::OUT_DATA_BITS-1:0] m_tdata
);

	logic [tadc_pkg::ANGLE_BITS-1:0] angle;
	logic [3:0]                      tens, ones;
	logic [7:0]                      bar;

	assign angle = m_tdata[6:0];
	assign tens  = m_tdata[11:8];
	assign ones  = m_tdata[15:12];
	assign bar   = m_tdata[23:16];

	// A result that is not taken stays on the bus unchanged.
	`TADC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// The angle never exceeds ninety degrees.
	`TADC_ASSERT_NOW(a_range, !m_tvalid || (angle <= tadc_pkg::FULL_DEG), "angle above ninety")

	// The digits spell the angle.
	`TADC_ASSERT_NOW(a_digits, !m_tvalid || ((ones <= 4'd9) && (7'(tens) * 7'd10 + 7'(ones) == angle)), "digits do not match angle")

	// The bar is full exactly at ninety degrees.
	`TADC_ASSERT_NOW(a_bar, !m_tvalid || ((angle == tadc_pkg::FULL_DEG) == (bar == 8'hFF)), "bar does not match angle")

	// An empty output register never blocks the input.
	`TADC_ASSERT_NOW(a_ready, m_tvalid || s_tready, "input blocked with empty output")

endmodule

bind tilt_angle_display_coder_core tadc_checker u_tadc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
